/* rtl/lcdesc_pkg.sv */
// Shared types and codes for the LCD escape stream and LED blink block.
`default_nettype none
package lcdesc_pkg;

  // Parser modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CMD  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;
  localparam logic [1:0] MODE_LED  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_LED  = 2'd2;

  // Escape bytes seen in idle mode
  localparam logic [7:0] ESC_CLEAR = 8'h03;
  localparam logic [7:0] ESC_CMD   = 8'h12;
  localparam logic [7:0] ESC_DATA  = 8'h14;
  localparam logic [7:0] ESC_LED   = 8'h16;

  // LCD controller commands
  localparam logic [7:0] LCD_CLR   = 8'h01;
  localparam logic [7:0] LCD_HOME  = 8'h02;

  // Colour codes
  localparam logic [7:0] COLOR_BLUE   = 8'd1;
  localparam logic [7:0] COLOR_RED    = 8'd2;
  localparam logic [7:0] COLOR_YELLOW = 8'd3;

  localparam int STEP_W = 5;
  localparam int PAT_W  = 32;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] lcd_byte;
    logic       led_blue;
    logic       led_red;
    logic       led_yellow;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [1:0] count;
  } push_t;

endpackage
`default_nettype wire

/* rtl/lcdesc_decode.sv */
// Parser and blink state with the per-item result decode.
`default_nettype none
module lcdesc_decode #(
  parameter int BLINK_STEPS   = 20,
  parameter int PATTERN_BYTES = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic                cmd,
  input  wire logic [7:0]          byte_value,
  output logic [1:0]               count,
  output lcdesc_pkg::result_t      res0,
  output lcdesc_pkg::result_t      res1
);

  logic [1:0]                      parse_mode, parse_mode_next;
  logic [2:0]                      bytes_left, bytes_left_next;
  logic [7:0]                      color_select, color_select_next;
  logic [lcdesc_pkg::PAT_W-1:0]    blue_pattern, blue_pattern_next;
  logic [lcdesc_pkg::PAT_W-1:0]    red_pattern, red_pattern_next;
  logic [lcdesc_pkg::PAT_W-1:0]    yellow_pattern, yellow_pattern_next;
  logic [lcdesc_pkg::STEP_W-1:0]   blink_step, blink_step_next;
  logic [lcdesc_pkg::STEP_W:0]     step_inc;

  assign step_inc = {1'b0, blink_step} + {{lcdesc_pkg::STEP_W{1'b0}}, 1'b1};

  always_comb begin
    parse_mode_next     = parse_mode;
    bytes_left_next     = bytes_left;
    color_select_next   = color_select;
    blue_pattern_next   = blue_pattern;
    red_pattern_next    = red_pattern;
    yellow_pattern_next = yellow_pattern;
    blink_step_next     = blink_step;
    count               = 2'd0;
    res0                = '0;
    res1                = '0;
    if (cmd) begin
      res0.kind       = lcdesc_pkg::KIND_LED;
      res0.led_blue   = blue_pattern[blink_step];
      res0.led_red    = red_pattern[blink_step];
      res0.led_yellow = yellow_pattern[blink_step];
      res0.last       = 1'b1;
      count           = 2'd1;
      if (step_inc >= (lcdesc_pkg::STEP_W+1)'(BLINK_STEPS) || step_inc[lcdesc_pkg::STEP_W])
        blink_step_next = '0;
      else
        blink_step_next = step_inc[lcdesc_pkg::STEP_W-1:0];
    end else begin
      case (parse_mode)
        lcdesc_pkg::MODE_CMD, lcdesc_pkg::MODE_DATA: begin
          res0.kind       = (parse_mode == lcdesc_pkg::MODE_CMD) ?
                            lcdesc_pkg::KIND_CMD : lcdesc_pkg::KIND_DATA;
          res0.lcd_byte   = byte_value;
          res0.last       = 1'b1;
          count           = 2'd1;
          parse_mode_next = lcdesc_pkg::MODE_IDLE;
        end
        lcdesc_pkg::MODE_LED: begin
          if (bytes_left == 3'(PATTERN_BYTES)) begin
            color_select_next = byte_value;
          end else if (color_select == lcdesc_pkg::COLOR_BLUE) begin
            blue_pattern_next = {blue_pattern[lcdesc_pkg::PAT_W-9:0], byte_value};
          end else if (color_select == lcdesc_pkg::COLOR_RED) begin
            red_pattern_next = {red_pattern[lcdesc_pkg::PAT_W-9:0], byte_value};
          end else if (color_select == lcdesc_pkg::COLOR_YELLOW) begin
            yellow_pattern_next = {yellow_pattern[lcdesc_pkg::PAT_W-9:0], byte_value};
          end
          if (bytes_left == 3'd0) begin
            parse_mode_next   = lcdesc_pkg::MODE_IDLE;
            color_select_next = 8'd0;
          end else begin
            bytes_left_next = bytes_left - 3'd1;
          end
        end
        default: begin
          case (byte_value)
            lcdesc_pkg::ESC_CLEAR: begin
              res0.kind     = lcdesc_pkg::KIND_CMD;
              res0.lcd_byte = lcdesc_pkg::LCD_CLR;
              res1.kind     = lcdesc_pkg::KIND_CMD;
              res1.lcd_byte = lcdesc_pkg::LCD_HOME;
              res1.last     = 1'b1;
              count         = 2'd2;
            end
            lcdesc_pkg::ESC_CMD:  parse_mode_next = lcdesc_pkg::MODE_CMD;
            lcdesc_pkg::ESC_DATA: parse_mode_next = lcdesc_pkg::MODE_DATA;
            lcdesc_pkg::ESC_LED: begin
              parse_mode_next = lcdesc_pkg::MODE_LED;
              bytes_left_next = 3'(PATTERN_BYTES);
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode     <= lcdesc_pkg::MODE_IDLE;
      bytes_left     <= 3'd0;
      color_select   <= 8'd0;
      blue_pattern   <= {{(lcdesc_pkg::PAT_W-1){1'b0}}, 1'b1};
      red_pattern    <= '0;
      yellow_pattern <= '0;
      blink_step     <= '0;
    end else if (take) begin
      parse_mode     <= parse_mode_next;
      bytes_left     <= bytes_left_next;
      color_select   <= color_select_next;
      blue_pattern   <= blue_pattern_next;
      red_pattern    <= red_pattern_next;
      yellow_pattern <= yellow_pattern_next;
      blink_step     <= blink_step_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/lcdesc_outq.sv */
// Two-slot result queue; slot 0 is the output register.
`default_nettype none
module lcdesc_outq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lcdesc_pkg::push_t   push,
  input  wire lcdesc_pkg::result_t res0,
  input  wire lcdesc_pkg::result_t res1,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output lcdesc_pkg::result_t      head,
  output logic [1:0]               room,
  output logic [1:0]               occ
);

  lcdesc_pkg::result_t slot0, slot1;
  lcdesc_pkg::result_t slot0_next, slot1_next;
  logic [1:0]          occ_next, kept;
  logic                pop;

  assign out_valid = (occ != 2'd0);
  assign head      = slot0;
  assign pop       = out_valid && !out_stall;
  assign kept      = occ - {1'b0, pop};
  assign room      = 2'd2 - kept;

  always_comb begin
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    occ_next   = kept;
    if (push.en) begin
      occ_next = kept + push.count;
      if (kept == 2'd0) begin
        if (push.count != 2'd0) slot0_next = res0;
        if (push.count == 2'd2) slot1_next = res1;
      end else if (kept == 2'd1) begin
        if (push.count != 2'd0) slot1_next = res0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) occ <= 2'd0;
    else     occ <= occ_next;
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule
`default_nettype wire

/* rtl/lcd_escape_stream_led_blinker_top.sv */
// Top level: input register, escape parser and blink sequencer, result queue.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------------
//   input   | in_valid, in_stall | cmd, byte_value
//   output  | out_valid,out_stall| kind, lcd_byte, led_blue, led_red, led_yellow, last
//
// One item per cycle enters the input register while in_stall is low; it is decoded from
// that register into the two-slot result queue, whose slot 0 drives the outputs.
// A clear byte yields two results and holds the input until the queue can take both;
// every other item waits only for room for the one result it yields, if any.
// Synchronous reset clears the parser, the step and the queue; blue pattern resets to 1.
// A stalled output keeps its result and fills the queue, then stalls the input.
`default_nettype none
module lcd_escape_stream_led_blinker_top #(
  parameter int BLINK_STEPS   = 20,
  parameter int PATTERN_BYTES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       cmd,
  input  wire logic [7:0] byte_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      lcd_byte,
  output logic            led_blue,
  output logic            led_red,
  output logic            led_yellow,
  output logic            last
);

  logic                q_valid;
  logic                q_cmd;
  logic [7:0]          q_byte;
  logic [1:0]          count, room, occ;
  logic                take;
  lcdesc_pkg::result_t res0, res1, head;
  lcdesc_pkg::push_t   push;

  assign take     = q_valid && (count <= room);
  assign in_stall = q_valid && !take;
  assign push.en    = take;
  assign push.count = count;

  always_ff @(posedge clk) begin
    if (rst)                        q_valid <= 1'b0;
    else if (in_valid && !in_stall) q_valid <= 1'b1;
    else if (take)                  q_valid <= 1'b0;
  end

  // Hold the payload while it waits
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_cmd  <= cmd;
      q_byte <= byte_value;
    end
  end

  lcdesc_decode #(
    .BLINK_STEPS   (BLINK_STEPS),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .cmd        (q_cmd),
    .byte_value (q_byte),
    .count      (count),
    .res0       (res0),
    .res1       (res1)
  );

  lcdesc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .room      (room),
    .occ       (occ)
  );

  assign kind       = head.kind;
  assign lcd_byte   = head.lcd_byte;
  assign led_blue   = head.led_blue;
  assign led_red    = head.led_red;
  assign led_yellow = head.led_yellow;
  assign last       = head.last;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= 2'd2)
    else $error("result queue overfilled");

  a_lcd_leds_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != lcdesc_pkg::KIND_LED |-> !(led_blue || led_red || led_yellow))
    else $error("LCD result carries LED bits");

  a_led_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == lcdesc_pkg::KIND_LED |-> lcd_byte == 8'd0 && last)
    else $error("LED result malformed");

  a_clear_shown: assert property (@(posedge clk) disable iff (rst)
    push.en && push.count == 2'd2 |=> out_valid && kind == lcdesc_pkg::KIND_CMD)
    else $error("clear results not presented");

endmodule
`default_nettype wire

/* tb/sv/lcd_escape_stream_checker.sv */
`timescale 1ns / 1ps
// Checker: predicts LCD writes and LED updates from accepted input and compares results.
module lcd_escape_stream_checker #(
  parameter int BLINK_STEPS   = 20,
  parameter int PATTERN_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] byte_value,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] kind,
  input  logic [7:0] lcd_byte,
  input  logic       led_blue,
  input  logic       led_red,
  input  logic       led_yellow,
  input  logic       last,
  output int         mismatches,
  output int         outstanding
);

  lcdesc_pkg::result_t expected_writes[$];
  lcdesc_pkg::result_t want;
  logic [1:0] mode;
  logic [2:0] pat_left;
  logic [7:0] colour;
  logic [31:0] blue_pat, red_pat, yellow_pat;
  logic [4:0] step;

  function automatic lcdesc_pkg::result_t lcd_write(logic [1:0] k, logic [7:0] v,
                                                    logic fin);
    lcdesc_pkg::result_t r;
    r = '0;
    r.kind     = k;
    r.lcd_byte = v;
    r.last     = fin;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  task automatic interpret_item(input logic is_tick, input logic [7:0] b);
    lcdesc_pkg::result_t r;
    if (is_tick) begin
      r = '0;
      r.kind       = lcdesc_pkg::KIND_LED;
      r.led_blue   = blue_pat[step];
      r.led_red    = red_pat[step];
      r.led_yellow = yellow_pat[step];
      r.last       = 1'b1;
      expected_writes.push_back(r);
      if (int'(step) + 1 >= BLINK_STEPS || int'(step) + 1 > 31) step = '0;
      else step = step + 5'd1;
      return;
    end
    case (mode)
      lcdesc_pkg::MODE_CMD: begin
        mode = lcdesc_pkg::MODE_IDLE;
        expected_writes.push_back(lcd_write(lcdesc_pkg::KIND_CMD, b, 1'b1));
      end
      lcdesc_pkg::MODE_DATA: begin
        mode = lcdesc_pkg::MODE_IDLE;
        expected_writes.push_back(lcd_write(lcdesc_pkg::KIND_DATA, b, 1'b1));
      end
      lcdesc_pkg::MODE_LED: begin
        // first byte of a load picks the colour, the rest shift into its pattern
        if (pat_left == 3'(PATTERN_BYTES)) colour = b;
        else if (colour == lcdesc_pkg::COLOR_BLUE) blue_pat = {blue_pat[23:0], b};
        else if (colour == lcdesc_pkg::COLOR_RED) red_pat = {red_pat[23:0], b};
        else if (colour == lcdesc_pkg::COLOR_YELLOW) yellow_pat = {yellow_pat[23:0], b};
        if (pat_left == '0) begin
          mode   = lcdesc_pkg::MODE_IDLE;
          colour = '0;
        end else begin
          pat_left = pat_left - 3'd1;
        end
      end
      default: begin
        case (b)
          lcdesc_pkg::ESC_CLEAR: begin
            expected_writes.push_back(lcd_write(lcdesc_pkg::KIND_CMD, lcdesc_pkg::LCD_CLR,
                                                1'b0));
            expected_writes.push_back(lcd_write(lcdesc_pkg::KIND_CMD, lcdesc_pkg::LCD_HOME,
                                                1'b1));
          end
          lcdesc_pkg::ESC_CMD:  mode = lcdesc_pkg::MODE_CMD;
          lcdesc_pkg::ESC_DATA: mode = lcdesc_pkg::MODE_DATA;
          lcdesc_pkg::ESC_LED: begin
            mode     = lcdesc_pkg::MODE_LED;
            pat_left = 3'(PATTERN_BYTES);
          end
          default: ;
        endcase
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_writes.delete();
      mode        = lcdesc_pkg::MODE_IDLE;
      pat_left    = '0;
      colour      = '0;
      blue_pat    = 32'd1;
      red_pat     = '0;
      yellow_pat  = '0;
      step        = '0;
      mismatches  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected result: kind %0d lcd_byte %0d", kind, lcd_byte);
          mismatches++;
        end else begin
          want = expected_writes.pop_front();
          check_field("kind", want.kind, kind);
          check_field("lcd_byte", want.lcd_byte, lcd_byte);
          check_field("led_blue", want.led_blue, led_blue);
          check_field("led_red", want.led_red, led_red);
          check_field("led_yellow", want.led_yellow, led_yellow);
          check_field("last", want.last, last);
        end
      end
      if (in_valid && !in_stall) interpret_item(cmd, byte_value);
    end
    outstanding = expected_writes.size();
  end

endmodule

/* tb/sv/lcd_escape_stream_led_blinker_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top: drives host bytes and blink ticks into the block and gives the verdict.
module lcd_escape_stream_led_blinker_top_tb;

  localparam int PATTERN_BYTES = 4;
  localparam int PHASE_ITEMS   = 442;
  localparam int QUIET_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       cmd = 1'b0;
  logic [7:0] byte_value = '0;
  logic       out_stall = 1'b0;
  logic       in_stall, out_valid;
  logic [1:0] kind;
  logic [7:0] lcd_byte;
  logic       led_blue, led_red, led_yellow, last;
  int         mismatches, outstanding;
  int         send_idle_pct = 25;
  int         recv_idle_pct = 63;
  int         quiet_cycles = 0;

  lcd_escape_stream_led_blinker_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .byte_value(byte_value),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .lcd_byte(lcd_byte),
    .led_blue(led_blue), .led_red(led_red), .led_yellow(led_yellow), .last(last)
  );

  lcd_escape_stream_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .byte_value(byte_value),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .lcd_byte(lcd_byte),
    .led_blue(led_blue), .led_red(led_red), .led_yellow(led_yellow), .last(last),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // end the run if neither channel moves a transfer for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lcd_escape_stream_led_blinker_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic is_tick, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= is_tick;
    byte_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_led_load(input logic [7:0] colour_code);
    send_item(1'b0, lcdesc_pkg::ESC_LED);
    send_item(1'b0, colour_code);
    repeat (PATTERN_BYTES) begin
      // a tick in the middle of a load must not disturb the parser
      if ($urandom_range(7) == 0) send_item(1'b1, 8'($urandom_range(255)));
      send_item(1'b0, 8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int items);
    int sent;
    int pick;
    logic [7:0] colour_code;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_item(1'b1, 8'($urandom_range(255)));
        sent++;
      end else if (pick < 40) begin
        send_item(1'b0, lcdesc_pkg::ESC_CLEAR);
        sent++;
      end else if (pick < 55) begin
        send_item(1'b0, lcdesc_pkg::ESC_CMD);
        send_item(1'b0, 8'($urandom_range(255)));
        sent += 2;
      end else if (pick < 70) begin
        send_item(1'b0, lcdesc_pkg::ESC_DATA);
        send_item(1'b0, 8'($urandom_range(255)));
        sent += 2;
      end else if (pick < 90) begin
        if ($urandom_range(9) == 0) colour_code = 8'($urandom_range(255));
        else colour_code = 8'($urandom_range(3, 1));
        send_led_load(colour_code);
        sent += 2 + PATTERN_BYTES;
      end else begin
        // stray byte: may be ignored or may break into a sequence
        send_item(1'b0, 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(1'b1, 8'h00);
    send_item(1'b0, lcdesc_pkg::ESC_CLEAR);
    send_item(1'b0, lcdesc_pkg::ESC_CMD);
    send_item(1'b0, 8'h00);
    send_item(1'b0, lcdesc_pkg::ESC_DATA);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, lcdesc_pkg::ESC_LED);
    send_item(1'b0, lcdesc_pkg::COLOR_BLUE);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hAA);
    send_item(1'b0, 8'h55);
    // unknown colour: pattern bytes are swallowed
    send_item(1'b0, lcdesc_pkg::ESC_LED);
    send_item(1'b0, 8'h07);
    send_item(1'b0, 8'h11);
    send_item(1'b0, 8'h22);
    send_item(1'b0, 8'h33);
    send_item(1'b0, 8'h44);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, lcdesc_pkg::ESC_CMD);
    send_item(1'b0, lcdesc_pkg::ESC_CLEAR);

    run_random(PHASE_ITEMS);
    send_idle_pct = 63;
    recv_idle_pct = 25;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("lcd_escape_stream_led_blinker_top verification clean");
    end else begin
      $display("lcd_escape_stream_led_blinker_top verification failed");
    end
    $finish;
  end

endmodule
